### design/stbs_pkg.sv
// Shared types and constants of the sorted table search block.
package stbs_pkg;

  // Field widths of the stream and configuration interfaces
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned TDATA_IN_W  = 80;
  localparam int unsigned TDATA_OUT_W = 8;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  // Register index, taken from paddr[2]
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SEARCH = 1'b1
  } req_e;

  // Source of the table read address
  typedef enum logic [1:0] {
    RD_ZERO     = 2'd0,
    RD_LAST     = 2'd1,
    RD_MID_INIT = 2'd2,
    RD_NEXT     = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    wr_en;
    logic    load_search;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    set_res;
    logic    res_val;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic below_first;
    logic above_last;
    logic hit;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

### design/stbs_dp.sv
// Datapath: entry table, search bounds, compare logic and result register.
module stbs_dp #(
  parameter int unsigned MaxEntries = stbs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stbs_pkg::cmd_t                 cmd_i,
  output stbs_pkg::sts_t                 sts_o,
  input  logic [stbs_pkg::CNT_W-1:0]     entry_count_i,
  input  logic [stbs_pkg::IDX_W-1:0]     entry_index_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] entry_value_i,
  input  logic signed [stbs_pkg::VAL_W-1:0] target_i,
  input  logic                           m_ready_i,
  output logic                           m_valid_o,
  output logic                           found_o
);
  import stbs_pkg::*;

  localparam int unsigned AW   = $clog2(MaxEntries);
  localparam int unsigned CntW = AW + 1;

  logic signed [VAL_W-1:0] mem_q [MaxEntries];
  logic signed [VAL_W-1:0] rdata_q;
  logic signed [VAL_W-1:0] target_q;
  logic [CntW-1:0]         count_q;
  logic [CntW-1:0]         count_eff;
  logic [AW-1:0]           lo_q, hi_q, mid_q;
  logic [AW-1:0]           lo_n, hi_n, mid_n, span;
  logic [AW-1:0]           last_idx;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic                    idx_ok;
  logic                    probe_lt;
  logic                    bounds_en;
  logic                    res_q;
  logic                    found_q;
  logic                    m_valid_q;

  // Clamp the count to the table depth
  always_comb begin
    if (32'(entry_count_i) > 32'(MaxEntries)) begin
      count_eff = CntW'(MaxEntries);
    end else begin
      count_eff = CntW'(entry_count_i);
    end
  end

  assign idx_ok   = 32'(entry_index_i) < 32'(MaxEntries);
  assign wr_addr  = AW'(entry_index_i);
  assign last_idx = AW'(count_q - CntW'(1));
  assign probe_lt = rdata_q < target_q;

  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    unique case (cmd_i.rd_sel)
      RD_MID_INIT: begin
        lo_n = '0;
        hi_n = last_idx;
      end
      RD_NEXT: begin
        if (probe_lt) begin
          lo_n = mid_q + AW'(1);
        end else begin
          hi_n = mid_q - AW'(1);
        end
      end
      default: begin
        lo_n = lo_q;
        hi_n = hi_q;
      end
    endcase
    span  = hi_n - lo_n;
    mid_n = lo_n + (span >> 1);
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = last_idx;
      default: rd_addr = mid_n;
    endcase
  end

  assign bounds_en = cmd_i.rd_en && (cmd_i.rd_sel == RD_MID_INIT || cmd_i.rd_sel == RD_NEXT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && idx_ok) begin
      mem_q[wr_addr] <= entry_value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_search) begin
      target_q <= target_i;
      count_q  <= count_eff;
    end
    if (bounds_en) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res_val;
    end
    if (cmd_i.out_load) begin
      found_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign sts_o.count_zero  = (entry_count_i == '0);
  assign sts_o.below_first = target_q < rdata_q;
  assign sts_o.above_last  = target_q > rdata_q;
  assign sts_o.hit         = (rdata_q == target_q);
  assign sts_o.exhausted   = probe_lt ? (mid_q == hi_q) : (mid_q == lo_q);
  assign sts_o.out_free    = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign found_o   = found_q;

endmodule

### design/stbs_ctrl.sv
// Controller: sequences table writes, range check and binary search probes.
module stbs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  input  logic           req_type_i,
  output logic           s_ready_o,
  input  stbs_pkg::sts_t sts_i,
  output stbs_pkg::cmd_t cmd_o
);
  import stbs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIRST = 5'b00010,
    S_LAST  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (req_type_i == REQ_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.load_search = 1'b1;
            if (sts_i.count_zero) begin
              cmd_o.set_res = 1'b1;
              cmd_o.res_val = 1'b0;
              state_d       = S_DONE;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_ZERO;
              state_d      = S_FIRST;
            end
          end
        end
      end
      S_FIRST: begin
        if (sts_i.below_first) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LAST;
          state_d      = S_LAST;
        end
      end
      S_LAST: begin
        if (sts_i.above_last) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_MID_INIT;
          state_d      = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts_i.hit) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_val = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.exhausted) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/sorted_table_binary_search.sv
// Write beat: the table is written on acceptance, and the block is ready again on the next cycle.
// Search beat: accept, read first entry, read last entry, then one probe per cycle
// (at most floor(log2(entry_count))+1 probes), then load the result register once
// the result stream is free; a target outside the first..last range skips the probes.
// The one-port table read with registered data sets the one-probe-per-cycle pace.
// Reset (async, active low) clears control state and entry_count; table contents stay undefined.
module sorted_table_binary_search #(
  parameter int unsigned MAX_ENTRIES = stbs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] entry_index, [41:10] entry_value, [73:42] target, [79:74] zero
  input  logic [stbs_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // [0] req_type
  input  logic                               s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] found, [7:1] zero
  output logic [stbs_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [stbs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [stbs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [stbs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import stbs_pkg::*;

  logic [CNT_W-1:0]        entry_count_q;
  logic                    cfg_wr;
  logic [IDX_W-1:0]        entry_index;
  logic signed [VAL_W-1:0] entry_value;
  logic signed [VAL_W-1:0] target;
  logic                    found;
  cmd_t                    cmd;
  sts_t                    sts;

  // Unpack the input beat
  assign entry_index = s_axis_tdata[IDX_W-1:0];
  assign entry_value = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
  assign target      = s_axis_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];

  // Configuration register: the user must write it only while the block is idle; the block does not enforce this
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_wr && paddr[2] == REG_ENTRY_COUNT) begin
      entry_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_ENTRY_COUNT) begin
      prdata = APB_DATA_W'(entry_count_q);
    end else begin
      prdata = '0;
    end
  end

  // Sequencer: range check on first and last entry, then probes
  stbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .req_type_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, bounds and result register
  stbs_dp #(
    .MaxEntries (MAX_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .entry_count_i (entry_count_q),
    .entry_index_i (entry_index),
    .entry_value_i (entry_value),
    .target_i      (target),
    .m_ready_i     (m_axis_tready),
    .m_valid_o     (m_axis_tvalid),
    .found_o       (found)
  );

  assign m_axis_tdata = {{(TDATA_OUT_W-1){1'b0}}, found};

  // A result appears only after the controller loaded it
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("result beat raised without a load");

  // The single table port never writes and reads together
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_en && cmd.rd_en))
    else $error("table written and read in one cycle");

  // After a write beat the block is ready again in the next cycle
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_WRITE) |=> s_axis_tready)
    else $error("not ready after a write beat");

  // A search holds off further beats
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_SEARCH) |=> !s_axis_tready)
    else $error("ready while a search is in flight");

endmodule
